FILE: sv/lpmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_pkg
// shared widths, codes and defaults of the length-prefixed message ring
// ----------------------------------------------------------------------------
package lpmr_pkg;

    localparam int FUNC_W   = 2;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 9;     // capacity, fill and remaining-byte counters
    localparam int DATA_W   = 32;    // apb data width
    localparam int ADDR_W   = 3;     // apb byte address width

    localparam int RING_DEPTH_DEF = 256;
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    // register word index
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SEND_START = 2'd0,
        FUNC_SEND_BYTE  = 2'd1,
        FUNC_READ_START = 2'd2,
        FUNC_READ_BYTE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_SMALL = 3'd3,
        ST_SEQ   = 3'd4
    } status_t;

endpackage

`default_nettype wire

FILE: sv/lpmr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr request and response channels
// valid/ready channels carrying one request word and one response word
// ----------------------------------------------------------------------------
interface lpmr_req_if;
    import lpmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [LEN_W-1:0]    msg_len;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    read_limit;

    modport source (output valid, output func, output msg_len, output data_byte,
                    output read_limit, input ready);
    modport sink   (input valid, input func, input msg_len, input data_byte,
                    input read_limit, output ready);
endinterface

interface lpmr_rsp_if;
    import lpmr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   read_byte;
    logic                last;

    modport source (output valid, output status, output length, output read_byte,
                    output last, input ready);
    modport sink   (input valid, input status, input length, input read_byte,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: sv/length_prefixed_message_ring_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// byte ring of variable-length messages, each a 2-byte length then payload
//
// req carries one request word (func, msg_len, data_byte, read_limit) and
// rsp returns exactly one response word per request (status, length,
// read_byte, last). A request is taken into the input stage, where the
// index and counter update is done, and its response goes into the output
// register once that register is free. One request per cycle is sustained
// while rsp does not stall; the limit is the single read and write port of
// each memory, whose read address is taken from the indices that the request ahead leaves behind.
// Payload bytes live in a RING_DEPTH-byte ram; message lengths are kept in
// a small header queue ram read in message order, so a start read costs
// one access like any other word.
// Reset empties the queue and sets capacity to 256; the memories need no
// clearing pass. A write to capacity over apb also empties the queue.
// When rsp stalls, one further request is taken into the input stage and
// then req.ready drops until the output register is freed.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core #(
    parameter int RING_DEPTH = lpmr_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lpmr_req_if.sink                           req,
    lpmr_rsp_if.source                         rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpmr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lpmr_pkg::DATA_W-1:0]   pwdata,
    output logic      [lpmr_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import lpmr_pkg::*;

    // ring index width and the largest capacity the counters can describe
    localparam int AW      = $clog2(RING_DEPTH);
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_MAX = (RING_DEPTH < CNT_MAX) ? RING_DEPTH : CNT_MAX;
    // every message takes at least two bytes, so this many headers at most
    localparam int HDR_MIN = CAP_MAX / 2;
    localparam int HAW     = $clog2(HDR_MIN);
    localparam int HDR_DEPTH = 1 << HAW;
    localparam int CW      = ((AW > CNT_W) ? AW : CNT_W) + 1;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                               input logic [CNT_W-1:0] c);
        logic [CW-1:0] inc;
        inc = CW'(i) + CW'(1);
        next_idx = (inc >= CW'(c)) ? '0 : inc[AW-1:0];
    endfunction

    // configuration
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] eff_cap;
    logic             cfg_wr;

    // queue state
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] send_left_reg, send_left_next;
    logic [CNT_W-1:0] read_left_reg, read_left_next;
    logic [HAW-1:0]   hw_ptr_reg, hw_ptr_next;
    logic [HAW-1:0]   hr_ptr_reg, hr_ptr_next;

    // input stage
    logic              s1_valid_reg;
    logic [FUNC_W-1:0] s1_func_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic [LEN_W-1:0]  s1_limit_reg;
    logic              s1_fire;
    logic              accept;

    // output register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [LEN_W-1:0]    rsp_length_reg;
    logic [BYTE_W-1:0]   rsp_byte_reg;
    logic                rsp_last_reg;
    status_t             status_c;
    logic [LEN_W-1:0]    length_c;
    logic [BYTE_W-1:0]   byte_c;
    logic                last_c;

    // memories and read-during-write bypass
    logic              ring_we;
    logic [BYTE_W-1:0] ring_q, ring_rd;
    logic              ring_byp_reg;
    logic [BYTE_W-1:0] ring_byp_data_reg;
    logic              hdr_we;
    logic [CNT_W-1:0]  hdr_q, hdr_rd;
    logic              hdr_byp_reg;
    logic [CNT_W-1:0]  hdr_byp_data_reg;

    logic [CNT_W-1:0]  free_c;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_reg) : '0;

    // 0 acts as 1, anything above the ring acts as the full ring
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(CAP_MAX))
        begin
            eff_cap = CNT_W'(CAP_MAX);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // ---------------------------------------------------------------- handshake
    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.length    = rsp_length_reg;
    assign rsp.read_byte = rsp_byte_reg;
    assign rsp.last      = rsp_last_reg;

    // data of the word in the input stage, with the write of the word ahead
    assign ring_q = ring_byp_reg ? ring_byp_data_reg : ring_rd;
    assign hdr_q  = hdr_byp_reg  ? hdr_byp_data_reg  : hdr_rd;

    assign free_c = (used_reg >= eff_cap) ? '0 : eff_cap - used_reg;

    // ---------------------------------------------------------------- step
    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        used_next      = used_reg;
        send_left_next = send_left_reg;
        read_left_next = read_left_reg;
        hw_ptr_next    = hw_ptr_reg;
        hr_ptr_next    = hr_ptr_reg;
        status_c       = ST_OK;
        length_c       = '0;
        byte_c         = '0;
        last_c         = 1'b0;
        ring_we        = 1'b0;
        hdr_we         = 1'b0;
        if (s1_fire)
        begin
            case (func_t'(s1_func_reg))
                FUNC_SEND_START:
                begin
                    if (send_left_reg != '0)
                    begin
                        status_c = ST_SEQ;
                    end
                    else if ((LEN_W + 1)'(s1_len_reg) + (LEN_W + 1)'(2) >
                             (LEN_W + 1)'(free_c))
                    begin
                        status_c = ST_FULL;
                    end
                    else
                    begin
                        // header skips two ring bytes, its value goes to the queue
                        hdr_we         = 1'b1;
                        hw_ptr_next    = hw_ptr_reg + HAW'(1);
                        wr_idx_next    = next_idx(next_idx(wr_idx_reg, eff_cap), eff_cap);
                        used_next      = used_reg + s1_len_reg[CNT_W-1:0] + CNT_W'(2);
                        send_left_next = s1_len_reg[CNT_W-1:0];
                    end
                end
                FUNC_SEND_BYTE:
                begin
                    if (send_left_reg == '0)
                    begin
                        status_c = ST_SEQ;
                    end
                    else
                    begin
                        ring_we        = 1'b1;
                        wr_idx_next    = next_idx(wr_idx_reg, eff_cap);
                        send_left_next = send_left_reg - CNT_W'(1);
                    end
                end
                FUNC_READ_START:
                begin
                    if (send_left_reg != '0 || read_left_reg != '0)
                    begin
                        status_c = ST_SEQ;
                    end
                    else if (used_reg == '0)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        length_c = LEN_W'(hdr_q);
                        if (LEN_W'(hdr_q) > s1_limit_reg)
                        begin
                            // too small: message stays at the head
                            status_c = ST_SMALL;
                        end
                        else
                        begin
                            hr_ptr_next    = hr_ptr_reg + HAW'(1);
                            rd_idx_next    = next_idx(next_idx(rd_idx_reg, eff_cap), eff_cap);
                            used_next      = (used_reg >= CNT_W'(2)) ?
                                             used_reg - CNT_W'(2) : '0;
                            read_left_next = hdr_q;
                        end
                    end
                end
                FUNC_READ_BYTE:
                begin
                    if (read_left_reg == '0)
                    begin
                        status_c = ST_SEQ;
                    end
                    else
                    begin
                        byte_c         = ring_q;
                        rd_idx_next    = next_idx(rd_idx_reg, eff_cap);
                        used_next      = (used_reg != '0) ? used_reg - CNT_W'(1) : '0;
                        read_left_next = read_left_reg - CNT_W'(1);
                        last_c         = (read_left_reg == CNT_W'(1));
                    end
                end
                default:
                begin
                    status_c = ST_SEQ;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- memories
    // payload bytes; read address is where the next word will find the head
    lpmr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wr_idx_reg),
        .wdata (s1_data_reg),
        .re    (accept),
        .raddr (rd_idx_next),
        .rdata (ring_rd)
    );

    // message lengths in send order
    lpmr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HDR_DEPTH),
        .AW    (HAW)
    ) u_hdr (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hw_ptr_reg),
        .wdata (s1_len_reg[CNT_W-1:0]),
        .re    (accept),
        .raddr (hr_ptr_next),
        .rdata (hdr_rd)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            used_reg      <= '0;
            send_left_reg <= '0;
            read_left_reg <= '0;
            hw_ptr_reg    <= '0;
            hr_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            ring_byp_reg  <= 1'b0;
            hdr_byp_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_CAPACITY)
            begin
                // capacity write empties the queue
                cap_reg       <= pwdata[CNT_W-1:0];
                wr_idx_reg    <= '0;
                rd_idx_reg    <= '0;
                used_reg      <= '0;
                send_left_reg <= '0;
                read_left_reg <= '0;
                hw_ptr_reg    <= '0;
                hr_ptr_reg    <= '0;
            end
            else
            begin
                wr_idx_reg    <= wr_idx_next;
                rd_idx_reg    <= rd_idx_next;
                used_reg      <= used_next;
                send_left_reg <= send_left_next;
                read_left_reg <= read_left_next;
                hw_ptr_reg    <= hw_ptr_next;
                hr_ptr_reg    <= hr_ptr_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                ring_byp_reg <= ring_we && (wr_idx_reg == rd_idx_next);
                hdr_byp_reg  <= hdr_we && (hw_ptr_reg == hr_ptr_next);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg       <= req.func;
            s1_len_reg        <= req.msg_len;
            s1_data_reg       <= req.data_byte;
            s1_limit_reg      <= req.read_limit;
            ring_byp_data_reg <= s1_data_reg;
            hdr_byp_data_reg  <= s1_len_reg[CNT_W-1:0];
        end
        if (s1_fire)
        begin
            rsp_status_reg <= status_c;
            rsp_length_reg <= length_c;
            rsp_byte_reg   <= byte_c;
            rsp_last_reg   <= last_c;
        end
    end

`ifndef SYNTH
    // fill never exceeds the ring in use
    a_used_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= eff_cap)
        else $error("fill count above capacity");

    // open send and open read are both counted in the fill
    a_left_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        send_left_reg <= used_reg && read_left_reg <= used_reg)
        else $error("remaining bytes exceed fill count");

    // indices stay inside the ring in use
    a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(wr_idx_reg) < CW'(eff_cap) && CW'(rd_idx_reg) < CW'(eff_cap))
        else $error("ring index beyond capacity");

    // a byte marked last closes the read
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && last_c && !(cfg_wr && paddr[2] == REG_CAPACITY))
        |=> read_left_reg == '0)
        else $error("read still open after last byte");
`endif

endmodule

`default_nettype wire

FILE: sv/lpmr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpmr_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lpmr_ram #(
    parameter int WIDTH = lpmr_pkg::BYTE_W,
    parameter int DEPTH = lpmr_pkg::RING_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sim/length_prefixed_message_ring_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core_tb
// self-checking bench for the length-prefixed message ring
//
// request words go in over the req channel and every response word is
// compared field by field with a behavioural copy of the ring kept here.
// a directed part covers reset state, out-of-sequence requests, a full
// message round trip with zero-length and too-small reads, and the queue
// flush on a capacity write. random traffic then runs mostly well-formed
// send and read sequences with some noise, over a sweep of capacities
// (including out-of-range values) and four idling modes on both channels.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core_tb;
    import lpmr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 160;
    // capacity sweep, out-of-range and tiny rings among them
    localparam int CAP_SWEEP [PHASES] = '{256, 3, 1, 2, 511, 0, 17, 257, 100, 5};

    typedef struct packed {
        status_t             status;
        logic [LEN_W-1:0]    length;
        logic [BYTE_W-1:0]   read_byte;
        logic                last;
    } rsp_word_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lpmr_req_if req_ch ();
    lpmr_rsp_if rsp_ch ();

    length_prefixed_message_ring_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // behavioural copy of the ring state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]   ring_mem [0:RING_DEPTH_DEF-1];
    logic [7:0]          wr_ptr;
    logic [7:0]          rd_ptr;
    logic [CNT_W-1:0]    fill;
    logic [CNT_W-1:0]    send_rem;
    logic [CNT_W-1:0]    read_rem;
    logic [CNT_W-1:0]    cap_reg;

    rsp_word_t           expected_rsp [$];

    int                  fail_count;
    int                  words_sent;
    int                  words_checked;
    int                  cycle_count;
    int                  status_seen [5];
    int                  src_idle_pct;
    int                  sink_stall_pct;

    // capacity as the ring actually uses it: 0 acts as 1, clamp at depth
    function automatic int live_capacity();
        if (cap_reg == 0)
            return 1;
        if (int'(cap_reg) > RING_DEPTH_DEF)
            return RING_DEPTH_DEF;
        return int'(cap_reg);
    endfunction

    function automatic logic [7:0] ring_next(logic [7:0] idx);
        int n;
        n = int'(idx) + 1;
        return (n >= live_capacity()) ? 8'd0 : 8'(n);
    endfunction

    function automatic void flush_ring();
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill     = '0;
        send_rem = '0;
        read_rem = '0;
    endfunction

    // works out the response word for one request and moves the state on
    function automatic rsp_word_t ring_response(func_t f, logic [LEN_W-1:0] len,
                                                logic [BYTE_W-1:0] dbyte,
                                                logic [LEN_W-1:0] lim);
        rsp_word_t  r;
        int         cap;
        int         free_b;
        logic [7:0] hi_ptr;
        logic [15:0] hdr;
        r.status    = ST_OK;
        r.length    = '0;
        r.read_byte = '0;
        r.last      = 1'b0;
        cap = live_capacity();
        case (f)
            FUNC_SEND_START:
            begin
                free_b = (int'(fill) >= cap) ? 0 : cap - int'(fill);
                if (send_rem != 0)
                    r.status = ST_SEQ;
                else if (int'(len) + 2 > free_b)
                    r.status = ST_FULL;
                else
                begin
                    // little-endian length header, then payload space reserved
                    ring_mem[wr_ptr] = len[7:0];
                    wr_ptr = ring_next(wr_ptr);
                    ring_mem[wr_ptr] = len[15:8];
                    wr_ptr = ring_next(wr_ptr);
                    fill = fill + len[CNT_W-1:0] + 9'd2;
                    send_rem = len[CNT_W-1:0];
                end
            end
            FUNC_SEND_BYTE:
            begin
                if (send_rem == 0)
                    r.status = ST_SEQ;
                else
                begin
                    ring_mem[wr_ptr] = dbyte;
                    wr_ptr = ring_next(wr_ptr);
                    send_rem = send_rem - 9'd1;
                end
            end
            FUNC_READ_START:
            begin
                if (send_rem != 0 || read_rem != 0)
                    r.status = ST_SEQ;
                else if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    hi_ptr = ring_next(rd_ptr);
                    hdr = {ring_mem[hi_ptr], ring_mem[rd_ptr]};
                    r.length = hdr;
                    // too small leaves the message queued as it was
                    if (hdr > lim)
                        r.status = ST_SMALL;
                    else
                    begin
                        rd_ptr = ring_next(hi_ptr);
                        fill = (fill >= 2) ? fill - 9'd2 : 9'd0;
                        read_rem = hdr[CNT_W-1:0];
                    end
                end
            end
            default:
            begin
                if (read_rem == 0)
                    r.status = ST_SEQ;
                else
                begin
                    r.read_byte = ring_mem[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    if (fill != 0)
                        fill = fill - 9'd1;
                    read_rem = read_rem - 9'd1;
                    r.last = (read_rem == 0);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, cycle limit, response side
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_rsp.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver readiness, redrawn every cycle
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // response checker: oldest expectation against every accepted word
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response word with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                words_checked++;
                status_seen[int'(want.status)]++;
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
                    fail_count++;
                end
                if (rsp_ch.read_byte !== want.read_byte)
                begin
                    $error("read_byte: expected 0x%02h, got 0x%02h",
                           want.read_byte, rsp_ch.read_byte);
                    fail_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request word, with random idle cycles ahead of it
    task automatic send_word(input func_t f, input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] dbyte,
                             input logic [LEN_W-1:0] lim);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.msg_len    <= len;
        req_ch.data_byte  <= dbyte;
        req_ch.read_limit <= lim;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        expected_rsp.push_back(ring_response(f, len, dbyte, lim));
        words_sent++;
    endtask

    // stop sending and let every response come back
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_read(output logic [DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // capacity write while idle, then read back; junk above bit 8 is masked
    task automatic write_capacity(input int value);
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] rdata;
        wdata = $urandom;
        wdata[CNT_W-1:0] = CNT_W'(value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        cap_reg = wdata[CNT_W-1:0];
        flush_ring();
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apb_read(rdata);
        if (rdata !== DATA_W'(cap_reg))
        begin
            $error("prdata: expected %0d, got %0d", cap_reg, rdata);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        logic [DATA_W-1:0] rdata;
        apb_read(rdata);
        if (rdata !== DATA_W'(CAP_RESET))
        begin
            $error("prdata: expected %0d, got %0d", CAP_RESET, rdata);
            fail_count++;
        end
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'hFFFF);   // empty queue
    endtask

    task automatic test_out_of_sequence();
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'h5A, 16'h0000);    // no open send
        send_word(FUNC_READ_BYTE, 16'hFFFF, 8'h00, 16'hFFFF);    // no open read
    endtask

    task automatic test_message_round_trip();
        send_word(FUNC_SEND_START, 16'hFFFF, 8'h00, 16'h0000);   // full
        send_word(FUNC_SEND_START, 16'h0000, 8'h00, 16'h0000);   // zero-length
        send_word(FUNC_SEND_START, 16'h0003, 8'h00, 16'h0000);
        send_word(FUNC_SEND_START, 16'h0001, 8'h00, 16'h0000);   // send already open
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'hFFFF);   // read while sending
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'h00, 16'h0000);
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'hFF, 16'h0000);
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'hA5, 16'h0000);
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'h0000);   // zero-length read
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'h0002);   // too small
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'hFFFF);
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'hFFFF);   // read already open
        repeat (3)
            send_word(FUNC_READ_BYTE, 16'h0000, 8'h00, 16'h0000);
        send_word(FUNC_READ_BYTE, 16'h0000, 8'h00, 16'h0000);    // past the last byte
    endtask

    task automatic test_capacity_flush();
        send_word(FUNC_SEND_START, 16'd255, 8'h00, 16'h0000);    // one byte too many
        send_word(FUNC_SEND_START, 16'd254, 8'h00, 16'h0000);    // fills the ring exactly
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'h11, 16'h0000);
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'h22, 16'h0000);
        write_capacity(256);                                     // flush mid-send
        send_word(FUNC_SEND_BYTE, 16'h0000, 8'h33, 16'h0000);
        send_word(FUNC_READ_START, 16'h0000, 8'h00, 16'hFFFF);
    endtask

    // mostly whole messages in and out, some noise and broken sequences
    task automatic test_random_traffic(input int n_words);
        int pick;
        int free_b;
        int max_len;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] lim;
        for (int k = 0; k < n_words; k++)
        begin
            pick = $urandom_range(99);
            if (send_rem != 0 && pick < 92)
                send_word(FUNC_SEND_BYTE, LEN_W'($urandom), BYTE_W'($urandom),
                          LEN_W'($urandom));
            else if (read_rem != 0 && pick < 92)
                send_word(FUNC_READ_BYTE, LEN_W'($urandom), BYTE_W'($urandom),
                          LEN_W'($urandom));
            else if (send_rem == 0 && read_rem == 0 && pick < 48)
            begin
                free_b = live_capacity() - int'(fill);
                if (free_b >= 2 && $urandom_range(9) < 8)
                begin
                    max_len = free_b - 2;
                    // mostly short messages, now and then as long as fits
                    if ($urandom_range(7) != 0 && max_len > 12)
                        max_len = 12;
                    len = LEN_W'($urandom_range(max_len));
                end
                else
                    len = LEN_W'($urandom);
                send_word(FUNC_SEND_START, len, BYTE_W'($urandom), LEN_W'($urandom));
            end
            else if (send_rem == 0 && read_rem == 0 && pick < 90)
            begin
                case ($urandom_range(19))
                    0, 1, 2:    lim = LEN_W'($urandom);
                    3, 4, 5:    lim = LEN_W'($urandom_range(16));
                    default:    lim = 16'hFFFF;
                endcase
                send_word(FUNC_READ_START, LEN_W'($urandom), BYTE_W'($urandom), lim);
            end
            else
                send_word(func_t'($urandom_range(3)), LEN_W'($urandom),
                          BYTE_W'($urandom), LEN_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_SEND_START;
        req_ch.msg_len    = '0;
        req_ch.data_byte  = '0;
        req_ch.read_limit = '0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        fail_count        = 0;
        words_sent        = 0;
        words_checked     = 0;
        cycle_count       = 0;
        foreach (status_seen[s])
            status_seen[s] = 0;
        cap_reg = CAP_RESET;
        flush_ring();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_out_of_sequence();
        test_message_round_trip();
        test_capacity_flush();

        // each capacity meets one idling mode; extremes spread over all four
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            write_capacity(CAP_SWEEP[p]);
            test_random_traffic(PHASE_WORDS);
        end

        drain();
        repeat (8) @(posedge clk);

        $display("%0d request words over %0d capacity settings, %0d responses checked",
                 words_sent, PHASES + 1, words_checked);
        $display("status mix: ok %0d, full %0d, empty %0d, too small %0d, out of seq %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
